// ----- sv/mhpq_pkg.sv -----
// shared types, constants and codes for the max heap priority queue
`default_nettype none

package mhpq_pkg;

   localparam int CAPACITY = 128;
   localparam int VALUE_W  = 32;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int ECOUNT_W = 8;
   localparam int RSP_W    = 2 * VALUE_W + ECOUNT_W;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_EMPTY    = 2'd2
   } status_type;

   typedef struct packed {
      logic                       insert;
      logic                       remove;
      logic signed [VALUE_W-1:0]  value;
   } cell_op_type;

endpackage

`default_nettype wire

// ----- sv/mhpq_cell.sv -----
// one slot of the sorted cell row, shifts toward or away from the head
`default_nettype none

module mhpq_cell (
   input  wire logic                              clock,
   input  wire mhpq_pkg::cell_op_type             op,
   input  wire logic                              occupied,
   input  wire logic                              prev_take,
   input  wire logic signed [mhpq_pkg::VALUE_W-1:0] prev_value,
   input  wire logic signed [mhpq_pkg::VALUE_W-1:0] next_value,
   output logic                                   take,
   output logic signed [mhpq_pkg::VALUE_W-1:0]    value
);

   logic signed [mhpq_pkg::VALUE_W-1:0] value_ff;
   logic signed [mhpq_pkg::VALUE_W-1:0] value_in;

   // new value lands here or closer to the head
   assign take  = !(occupied && (op.value <= value_ff));
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (op.insert && take) begin
         value_in = prev_take ? prev_value : op.value;
      end else if (op.remove) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ----- sv/max_heap_priority_queue.sv -----
// top level: bounded max priority queue built from a row of sorted cells
// latency: a result is shown in the cycle after the request transfer
// throughput: one request per cycle while the result side keeps up
// the rate is set by one broadcast compare across the cell row per request
// reset clears the element count and the result valid; cell contents stay
// undefined and are never read before they are written
`default_nettype none

module max_heap_priority_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [31:0]                   req_tdata,  // value
   input  wire logic [0:0]                    req_tuser,  // command
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [mhpq_pkg::RSP_W-1:0]         rsp_tdata,  // removed_value, current_max, element_count
   output logic [1:0]                         rsp_tuser   // status
);

   localparam int N = mhpq_pkg::CAPACITY;
   localparam int W = mhpq_pkg::VALUE_W;
   localparam int C = mhpq_pkg::COUNT_W;

   logic [C-1:0]                count_ff;
   logic [C-1:0]                count_in;
   logic                        rsp_tvalid_ff;
   logic [mhpq_pkg::RSP_W-1:0]  rsp_tdata_ff;
   logic [1:0]                  rsp_tuser_ff;
   logic [mhpq_pkg::RSP_W-1:0]  rsp_tdata_in;
   logic [1:0]                  rsp_tuser_in;

   mhpq_pkg::cell_op_type       op;
   logic signed [W-1:0]         cell_value [N];
   logic [N-1:0]                cell_take;

   logic                        req_fire;
   logic                        is_remove;
   logic                        full;
   logic                        empty;
   logic signed [W-1:0]         req_value;
   logic signed [W-1:0]         removed;
   logic signed [W-1:0]         max_value;
   mhpq_pkg::status_type        status;

   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_remove  = (req_tuser[0] == mhpq_pkg::CMD_REMOVE);
   assign full       = (count_ff == C'(N));
   assign empty      = (count_ff == '0);
   assign req_value  = req_tdata;

   assign op.insert = req_fire && !is_remove && !full;
   assign op.remove = req_fire && is_remove && !empty;
   assign op.value  = req_value;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                occ;
      logic                p_take;
      logic signed [W-1:0] p_value;
      logic signed [W-1:0] n_value;

      assign occ = (count_ff > C'(i));

      if (i == 0) begin : g_head
         assign p_take  = 1'b0;
         assign p_value = cell_value[i];
      end else begin : g_body
         assign p_take  = cell_take[i-1];
         assign p_value = cell_value[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign n_value = cell_value[i];
      end else begin : g_inner
         assign n_value = cell_value[i+1];
      end

      mhpq_cell u_cell (
         .clock      (clock),
         .op         (op),
         .occupied   (occ),
         .prev_take  (p_take),
         .prev_value (p_value),
         .next_value (n_value),
         .take       (cell_take[i]),
         .value      (cell_value[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status    = mhpq_pkg::STATUS_OK;
      removed   = '0;
      max_value = empty ? '0 : cell_value[0];
      if (!is_remove) begin
         if (full) begin
            status = mhpq_pkg::STATUS_OVERFLOW;
         end else begin
            count_in = count_ff + C'(1);
            if (empty || (req_value > cell_value[0])) begin
               max_value = req_value;
            end
         end
      end else begin
         if (empty) begin
            status = mhpq_pkg::STATUS_EMPTY;
         end else begin
            count_in  = count_ff - C'(1);
            removed   = cell_value[0];
            max_value = (count_ff > C'(1)) ? cell_value[1] : '0;
         end
      end
      rsp_tdata_in = {mhpq_pkg::ECOUNT_W'(count_in), max_value, removed};
      rsp_tuser_in = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff      <= count_in;
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

// ----- sv/mhpq_checker.sv -----
// port-level checks for the max heap priority queue, bound to the top level
`default_nettype none

module mhpq_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_tvalid,
   input wire logic                          req_tready,
   input wire logic [31:0]                   req_tdata,
   input wire logic [0:0]                    req_tuser,
   input wire logic                          rsp_tvalid,
   input wire logic                          rsp_tready,
   input wire logic [mhpq_pkg::RSP_W-1:0]    rsp_tdata,
   input wire logic [1:0]                    rsp_tuser
);

   localparam int W = mhpq_pkg::VALUE_W;

   logic [W-1:0]                  rsp_removed;
   logic [W-1:0]                  rsp_max;
   logic [mhpq_pkg::ECOUNT_W-1:0] rsp_count;

   assign rsp_removed = rsp_tdata[W-1:0];
   assign rsp_max     = rsp_tdata[2*W-1:W];
   assign rsp_count   = rsp_tdata[mhpq_pkg::RSP_W-1:2*W];

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // every request transfer yields a result next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("request transfer without result");

   // overflow only with a full queue
   a_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mhpq_pkg::STATUS_OVERFLOW) |->
         (rsp_count == mhpq_pkg::ECOUNT_W'(mhpq_pkg::CAPACITY)) && (rsp_removed == '0))
      else $error("overflow reported on a queue that is not full");

   // empty queue reports a zero maximum, and a zero removed value with the empty status
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_count == '0) |-> (rsp_max == '0) &&
         ((rsp_tuser != mhpq_pkg::STATUS_EMPTY) || (rsp_removed == '0)))
      else $error("empty queue reported a nonzero value");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

`default_nettype wire
